// ===== rtl/spom_pkg.sv =====
// ----------------------------------------------------------------------------
// spom_pkg
// Shared types, constants and helpers for the spiral order matrix fill block.
// ----------------------------------------------------------------------------
package spom_pkg;

  // default geometry and value width
  localparam int MAX_ROWS_DEF   = 64;
  localparam int MAX_COLS_DEF   = 64;
  localparam int VALUE_BITS_DEF = 16;

  // fixed field widths
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 16;
  localparam int IDX_W   = 6;
  localparam int CFG_W   = 7;
  localparam int CELL_W  = 17;

  // fill generation tag kept next to every stored value
  localparam int EPOCH_BITS  = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_PLACE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // configuration register indexes
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_PLACE,
    OP_READ,
    OP_RESTART
  } op_t;

  typedef enum logic [1:0] {
    ST_PLACED    = 2'd0,
    ST_DROPPED   = 2'd1,
    ST_READ      = 2'd2,
    ST_RESTARTED = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    DIR_RIGHT,
    DIR_DOWN,
    DIR_LEFT,
    DIR_UP
  } dir_t;

  typedef struct packed {
    op_t              op;
    logic [VAL_W-1:0] value;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             in_range;
  } item_t;

  // size register clamped to 1..maxv
  function automatic logic [CFG_W-1:0] clamp_size(input logic [CFG_W-1:0] v,
                                                  input int maxv);
    logic [CFG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = CFG_W'(1);
    end else if (int'(v) > maxv) begin
      r = CFG_W'(maxv);
    end
    return r;
  endfunction

endpackage

// ===== rtl/spom_ram.sv =====
// ----------------------------------------------------------------------------
// spom_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/spom_queue.sv =====
// ----------------------------------------------------------------------------
// spom_queue
// Short queue of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module spom_queue import spom_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t       slots [DEPTH];
  logic [PW:0] wr_ptr;
  logic [PW:0] rd_ptr;

  assign pop_valid = (wr_ptr != rd_ptr);
  assign full      = (wr_ptr[PW] != rd_ptr[PW]) && (wr_ptr[PW-1:0] == rd_ptr[PW-1:0]);
  assign pop_item  = slots[rd_ptr[PW-1:0]];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr[PW-1:0]] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/spom_front.sv =====
// ----------------------------------------------------------------------------
// spom_front
// Accepts input items, drops unused kinds, masks values and checks read range.
// ----------------------------------------------------------------------------
module spom_front import spom_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [KIND_W-1:0] kind,
  input  logic [VAL_W-1:0]  value,
  input  logic [IDX_W-1:0]  row,
  input  logic [IDX_W-1:0]  col,
  input  logic              q_full,
  input  logic              busy,
  output logic              q_push,
  output item_t             q_item
);

  localparam logic [VAL_W-1:0] VMASK = (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} :
                                       VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

  logic known;

  assign in_stall = q_full | busy;

  always_comb begin
    known        = 1'b1;
    q_item.op    = OP_PLACE;
    q_item.value = value & VMASK;
    q_item.row   = row;
    q_item.col   = col;
    q_item.in_range = (int'(row) < MAX_ROWS) && (int'(col) < MAX_COLS);
    case (kind)
      KIND_PLACE:   q_item.op = OP_PLACE;
      KIND_READ:    q_item.op = OP_READ;
      KIND_RESTART: q_item.op = OP_RESTART;
      default:      known = 1'b0;
    endcase
  end

  // unused kind is taken and forgotten
  assign q_push = in_valid & ~in_stall & known;

endmodule

// ===== rtl/spom_back.sv =====
// ----------------------------------------------------------------------------
// spom_back
// Spiral cursor, matrix store with fill tags, result stages and size registers.
// ----------------------------------------------------------------------------
module spom_back import spom_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     q_valid,
  input  item_t                    q_item,
  output logic                     q_pop,
  output logic                     busy,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [IDX_W-1:0]         cell_row,
  output logic [IDX_W-1:0]         cell_col,
  output logic signed [CELL_W-1:0] cell_value
);

  localparam int CELLS = MAX_ROWS * MAX_COLS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW    = (VALUE_BITS < VAL_W) ? VALUE_BITS : VAL_W;
  localparam int MW    = EPOCH_BITS + SW;
  localparam int RMAX  = (MAX_ROWS < 127) ? MAX_ROWS : 127;
  localparam int CMAX  = (MAX_COLS < 127) ? MAX_COLS : 127;
  localparam int PCW   = $clog2(RMAX * CMAX + 1);
  localparam int XW    = AW + CFG_W + 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  // size registers
  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;

  // spiral state
  logic [CFG_W-1:0] top_bound, bottom_bound, left_bound, right_bound;
  logic [CFG_W-1:0] cursor_row, cursor_col;
  dir_t             direction;
  logic [PCW-1:0]   placed_count;
  logic [PCW-1:0]   total_cells;
  logic [EPOCH_BITS-1:0] epoch;

  logic [CFG_W-1:0] top_bound_next, bottom_bound_next, left_bound_next, right_bound_next;
  logic [CFG_W-1:0] cursor_row_next, cursor_col_next;
  dir_t             direction_next;

  // clearing sweep
  logic          clearing;
  logic [AW-1:0] clr_addr;

  // restart load values
  logic [CFG_W-1:0] size_rows, size_cols;
  logic [PCW-1:0]   size_total;

  // pending stage (waits for ram read data)
  logic                  p_valid;
  status_t               p_status;
  logic [IDX_W-1:0]      p_row, p_col;
  logic [CELL_W-1:0]     p_value;
  logic                  p_read;
  logic                  p_ok;
  logic [EPOCH_BITS-1:0] p_epoch;

  // output register
  status_t           o_status;
  logic [CELL_W-1:0] o_value;

  logic          issue_ok, p_move, o_free, full, do_place, do_restart, do_read;
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;
  logic [XW-1:0] cur_lin, rd_lin;
  logic [CELL_W-1:0] read_value;

  assign busy = clearing;

  assign o_free   = ~out_valid | ~out_stall;
  assign p_move   = p_valid & o_free;
  assign issue_ok = ~clearing & (~p_valid | p_move);
  assign q_pop    = q_valid & issue_ok;

  assign full       = (placed_count >= total_cells);
  assign do_place   = q_pop && (q_item.op == OP_PLACE) && !full;
  assign do_restart = q_pop && (q_item.op == OP_RESTART);
  assign do_read    = q_pop && (q_item.op == OP_READ);

  assign size_rows  = clamp_size(rst ? SIZE_RESET : row_count, MAX_ROWS);
  assign size_cols  = clamp_size(rst ? SIZE_RESET : col_count, MAX_COLS);
  assign size_total = PCW'(size_rows) * PCW'(size_cols);

  assign cur_lin = XW'(cursor_row) * XW'(MAX_COLS) + XW'(cursor_col);
  assign rd_lin  = XW'(q_item.row) * XW'(MAX_COLS) + XW'(q_item.col);

  assign ram_we    = clearing | do_place;
  assign ram_waddr = clearing ? clr_addr : cur_lin[AW-1:0];
  assign ram_wdata = clearing ? '0 : {epoch, q_item.value[SW-1:0]};
  assign ram_re    = do_read;
  assign ram_raddr = rd_lin[AW-1:0];

  spom_ram #(
    .WIDTH(MW),
    .DEPTH(CELLS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // one step along the spiral
  always_comb begin
    top_bound_next    = top_bound;
    bottom_bound_next = bottom_bound;
    left_bound_next   = left_bound;
    right_bound_next  = right_bound;
    cursor_row_next   = cursor_row;
    cursor_col_next   = cursor_col;
    direction_next    = direction;
    case (direction)
      DIR_RIGHT: begin
        if (cursor_col < right_bound) begin
          cursor_col_next = cursor_col + 1'b1;
        end else begin
          top_bound_next  = top_bound + 1'b1;
          direction_next  = DIR_DOWN;
          cursor_row_next = cursor_row + 1'b1;
        end
      end
      DIR_DOWN: begin
        if (cursor_row < bottom_bound) begin
          cursor_row_next = cursor_row + 1'b1;
        end else begin
          right_bound_next = right_bound - 1'b1;
          direction_next   = DIR_LEFT;
          cursor_col_next  = cursor_col - 1'b1;
        end
      end
      DIR_LEFT: begin
        if (cursor_col > left_bound) begin
          cursor_col_next = cursor_col - 1'b1;
        end else begin
          bottom_bound_next = bottom_bound - 1'b1;
          direction_next    = DIR_UP;
          cursor_row_next   = cursor_row - 1'b1;
        end
      end
      default: begin
        if (cursor_row > top_bound) begin
          cursor_row_next = cursor_row - 1'b1;
        end else begin
          left_bound_next = left_bound + 1'b1;
          direction_next  = DIR_RIGHT;
          cursor_col_next = cursor_col + 1'b1;
        end
      end
    endcase
  end

  // a hit needs a matching fill tag from the current generation
  always_comb begin
    read_value = {CELL_W{1'b1}};
    if (p_ok && (ram_rdata[MW-1:SW] == p_epoch)) begin
      read_value = CELL_W'(ram_rdata[SW-1:0]);
    end
  end

  // control and spiral state
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= SIZE_RESET;
      col_count    <= SIZE_RESET;
      clearing     <= 1'b1;
      clr_addr     <= '0;
      epoch        <= EPOCH_BITS'(1);
      top_bound    <= '0;
      left_bound   <= '0;
      bottom_bound <= size_rows - 1'b1;
      right_bound  <= size_cols - 1'b1;
      total_cells  <= size_total;
      direction    <= DIR_RIGHT;
      cursor_row   <= '0;
      cursor_col   <= '0;
      placed_count <= '0;
      p_valid      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROW_COUNT) begin
          row_count <= cfg_data;
        end else begin
          col_count <= cfg_data;
        end
      end

      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == LAST_ADDR) begin
          clearing <= 1'b0;
        end
      end

      if (do_place) begin
        top_bound    <= top_bound_next;
        bottom_bound <= bottom_bound_next;
        left_bound   <= left_bound_next;
        right_bound  <= right_bound_next;
        cursor_row   <= cursor_row_next;
        cursor_col   <= cursor_col_next;
        direction    <= direction_next;
        placed_count <= placed_count + 1'b1;
      end

      if (do_restart) begin
        top_bound    <= '0;
        left_bound   <= '0;
        bottom_bound <= size_rows - 1'b1;
        right_bound  <= size_cols - 1'b1;
        total_cells  <= size_total;
        direction    <= DIR_RIGHT;
        cursor_row   <= '0;
        cursor_col   <= '0;
        placed_count <= '0;
        // out of fresh tags: wipe the store and start over
        if (epoch == {EPOCH_BITS{1'b1}}) begin
          epoch    <= EPOCH_BITS'(1);
          clearing <= 1'b1;
          clr_addr <= '0;
        end else begin
          epoch <= epoch + 1'b1;
        end
      end

      if (q_pop) begin
        p_valid <= 1'b1;
      end else if (p_move) begin
        p_valid <= 1'b0;
      end

      if (p_move) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // pending stage payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      p_read  <= do_read;
      p_ok    <= q_item.in_range;
      p_epoch <= epoch;
      p_row   <= '0;
      p_col   <= '0;
      p_value <= '0;
      case (q_item.op)
        OP_PLACE: begin
          p_value <= CELL_W'(q_item.value);
          if (full) begin
            p_status <= ST_DROPPED;
          end else begin
            p_status <= ST_PLACED;
            p_row    <= cursor_row[IDX_W-1:0];
            p_col    <= cursor_col[IDX_W-1:0];
          end
        end
        OP_READ: begin
          p_status <= ST_READ;
          p_row    <= q_item.row;
          p_col    <= q_item.col;
        end
        default: begin
          p_status <= ST_RESTARTED;
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (p_move) begin
      o_status <= p_status;
      cell_row <= p_row;
      cell_col <= p_col;
      o_value  <= p_read ? read_value : p_value;
    end
  end

  assign status     = o_status;
  assign cell_value = signed'(o_value);

endmodule

// ===== rtl/spiral_order_matrix_fill_core.sv =====
// ----------------------------------------------------------------------------
// spiral_order_matrix_fill_core
// Fills a matrix store in clockwise spiral order and answers cell reads.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake                  payload
//   input    in         in_valid / in_stall        kind, value, row, col
//   result   out        out_valid / out_stall      status, cell_row, cell_col,
//                                                  cell_value
//   config   in         cfg_we                     cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low and no sweep runs;
// out_valid rises after the transfer passes the queue write, the store access
// (pending stage) and the output register. after reset, and after every
// fifteenth restart, the whole store is swept clean while in_stall is held high.
// result stall backs up through the output register and the queue into in_stall.
//
module spiral_order_matrix_fill_core import spom_pkg::*; #(
  parameter int MAX_ROWS   = MAX_ROWS_DEF,
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [KIND_W-1:0]        kind,
  input  logic [VAL_W-1:0]         value,
  input  logic [IDX_W-1:0]         row,
  input  logic [IDX_W-1:0]         col,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               status,
  output logic [IDX_W-1:0]         cell_row,
  output logic [IDX_W-1:0]         cell_col,
  output logic signed [CELL_W-1:0] cell_value
);

  logic  q_full, q_push, q_pop, q_valid, busy;
  item_t push_item, pop_item;

  spom_front #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind    (kind),
    .value   (value),
    .row     (row),
    .col     (col),
    .q_full  (q_full),
    .busy    (busy),
    .q_push  (q_push),
    .q_item  (push_item)
  );

  spom_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_item (pop_item)
  );

  spom_back #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (pop_item),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cell_row  (cell_row),
    .cell_col  (cell_col),
    .cell_value(cell_value)
  );

endmodule
